>>> rtl/bsm_pkg.sv
// Package for the bounding sphere merge block: widths, controller states and
// the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package bsm_pkg;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned FracBits   = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_CMP,
    ST_SQRT,
    ST_DPREP,
    ST_DIV,
    ST_AXIS,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic cmp;
    logic sqrt_start;
    logic sqrt_step;
    logic dprep;
    logic div_start;
    logic div_step;
    logic axis;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic contained;
    logic sqrt_done;
    logic div_done;
    logic axis_last;
  } sts_t;

endpackage

>>> rtl/bsm_if.sv
// Valid/ready channel interfaces for the bounding sphere merge block.
// Depends on nothing; widths come from the instantiating module.
`timescale 1ns / 1ps
interface bsm_in_if #(parameter int unsigned W = 32) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] center_x;
  logic [W-1:0] center_y;
  logic [W-1:0] center_z;
  logic [W-2:0] radius;
  logic         first_of_set;
  logic         last_of_set;
  modport source (output valid, center_x, center_y, center_z, radius, first_of_set,
                  last_of_set, input ready);
  modport sink (input valid, center_x, center_y, center_z, radius, first_of_set,
                last_of_set, output ready);
endinterface

interface bsm_out_if #(parameter int unsigned W = 32) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] out_center_x;
  logic [W-1:0] out_center_y;
  logic [W-1:0] out_center_z;
  logic [W-2:0] out_radius;
  logic         radius_saturated;
  modport source (output valid, out_center_x, out_center_y, out_center_z, out_radius,
                  radius_saturated, input ready);
  modport sink (input valid, out_center_x, out_center_y, out_center_z, out_radius,
                radius_saturated, output ready);
endinterface

>>> rtl/bounding_sphere_merge.sv
// Top level of the bounding sphere merge block: controller plus datapath.
// Depends on bsm_pkg, bsm_if, bsm_ctrl and bsm_datapath.
//
// Spheres arrive on the valid/ready input channel; a transaction with
// first_of_set loads the running sphere, others merge into it. A transaction
// with last_of_set produces one result on the output channel.
// One item is handled at a time. A first item passes the idle and multiply
// states and a contained sphere also the sum and compare states, with the output
// state added when a result is written; a true merge runs a bit-serial square
// root (one bit per cycle) and three bit-serial divisions of the axis offsets,
// each with a setup and an update state.
// The result sits in an output register; the block takes the next item while
// it waits, and stalls only when a new result is due while one is still held.
// Reset clears the running sphere and any pending result.
`timescale 1ns / 1ps
module bounding_sphere_merge #(
  parameter int unsigned CoordWidth = bsm_pkg::CoordWidth
) (
  input logic clk_i,
  input logic rst_ni,
  bsm_in_if.sink    in_if,
  bsm_out_if.source out_if
);

  bsm_pkg::cmd_t cmd;
  bsm_pkg::sts_t sts;
  logic          out_free;

  bsm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bsm_datapath #(.CoordWidth(CoordWidth)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_x_i      (in_if.center_x),
    .in_y_i      (in_if.center_y),
    .in_z_i      (in_if.center_z),
    .in_r_i      (in_if.radius),
    .in_first_i  (in_if.first_of_set),
    .in_last_i   (in_if.last_of_set),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_free_o  (out_free),
    .out_x_o     (out_if.out_center_x),
    .out_y_o     (out_if.out_center_y),
    .out_z_o     (out_if.out_center_z),
    .out_r_o     (out_if.out_radius),
    .out_sat_o   (out_if.radius_saturated)
  );

endmodule

>>> rtl/bsm_ctrl.sv
// Controller state machine for the bounding sphere merge block.
// Depends on bsm_pkg.
`timescale 1ns / 1ps
module bsm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_free_i,
  input  bsm_pkg::sts_t   sts_i,
  output bsm_pkg::cmd_t   cmd_o
);

  bsm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= bsm_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsm_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = bsm_pkg::ST_MUL;
      end
      bsm_pkg::ST_MUL: begin
        if (sts_i.first) state_d = sts_i.last ? bsm_pkg::ST_OUT : bsm_pkg::ST_IDLE;
        else             state_d = bsm_pkg::ST_SUM;
      end
      bsm_pkg::ST_SUM: state_d = bsm_pkg::ST_CMP;
      bsm_pkg::ST_CMP: begin
        if (sts_i.contained) state_d = sts_i.last ? bsm_pkg::ST_OUT : bsm_pkg::ST_IDLE;
        else                 state_d = bsm_pkg::ST_SQRT;
      end
      bsm_pkg::ST_SQRT: if (sts_i.sqrt_done) state_d = bsm_pkg::ST_DPREP;
      bsm_pkg::ST_DPREP: state_d = bsm_pkg::ST_DIV;
      bsm_pkg::ST_DIV: if (sts_i.div_done) state_d = bsm_pkg::ST_AXIS;
      bsm_pkg::ST_AXIS: begin
        if (sts_i.axis_last) state_d = sts_i.last ? bsm_pkg::ST_OUT : bsm_pkg::ST_IDLE;
        else                 state_d = bsm_pkg::ST_DPREP;
      end
      bsm_pkg::ST_OUT: if (out_free_i) state_d = bsm_pkg::ST_IDLE;
      default: state_d = bsm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bsm_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      bsm_pkg::ST_MUL:  cmd_o.mul = 1'b1;
      bsm_pkg::ST_SUM:  cmd_o.sum = 1'b1;
      bsm_pkg::ST_CMP: begin
        cmd_o.cmp        = 1'b1;
        cmd_o.sqrt_start = !sts_i.contained;
      end
      bsm_pkg::ST_SQRT:  cmd_o.sqrt_step = 1'b1;
      bsm_pkg::ST_DPREP: begin
        cmd_o.dprep     = 1'b1;
        cmd_o.div_start = 1'b1;
      end
      bsm_pkg::ST_DIV:  cmd_o.div_step = 1'b1;
      bsm_pkg::ST_AXIS: cmd_o.axis = 1'b1;
      bsm_pkg::ST_OUT:  cmd_o.out_load = out_free_i;
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == bsm_pkg::ST_IDLE)
    else $error("ready outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == bsm_pkg::ST_MUL)
    else $error("load did not start work");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsm_pkg::ST_SQRT && !sts_i.sqrt_done) |=> state_q == bsm_pkg::ST_SQRT)
    else $error("root left early");

endmodule

>>> rtl/bsm_datapath.sv
// Datapath for the bounding sphere merge block: running sphere, squared
// distance, bit-serial square root and divider, output register. Uses bsm_pkg.
`timescale 1ns / 1ps
module bsm_datapath #(
  parameter int unsigned CoordWidth = bsm_pkg::CoordWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bsm_pkg::cmd_t         cmd_i,
  output bsm_pkg::sts_t         sts_o,
  input  logic [CoordWidth-1:0] in_x_i,
  input  logic [CoordWidth-1:0] in_y_i,
  input  logic [CoordWidth-1:0] in_z_i,
  input  logic [CoordWidth-2:0] in_r_i,
  input  logic                  in_first_i,
  input  logic                  in_last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  out_free_o,
  output logic [CoordWidth-1:0] out_x_o,
  output logic [CoordWidth-1:0] out_y_o,
  output logic [CoordWidth-1:0] out_z_o,
  output logic [CoordWidth-2:0] out_r_o,
  output logic                  out_sat_o
);

  localparam int unsigned W   = CoordWidth;
  localparam int unsigned DW  = W + 1;
  localparam int unsigned SW  = 2 * DW + 2;
  localparam int unsigned RW  = DW + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned NI  = RW;
  localparam int unsigned QW  = PW + 1;
  localparam int unsigned CNTW = $clog2(PW + 2);

  localparam logic signed [DW:0] CMaxL = {{(DW-W+1){1'b0}}, 1'b0, {(W-1){1'b1}}};
  localparam logic signed [DW:0] CMinL = {{(DW-W+1){1'b1}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [RW-1:0]      RMaxL = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};

  logic signed [W-1:0] cx_q [3];
  logic signed [W-1:0] nx_q [3];
  logic [W-2:0]        r1_q, r2_q;
  logic                sat_q, first_q, last_q;
  logic [DW-1:0]       da_q [3];
  logic [2:0]          dneg_q;
  logic [DW-1:0]       dr_q;
  logic                drneg_q;
  logic [PW-1:0]       sq_q [3];
  logic [PW-1:0]       drsq_q;
  logic                cont_q;
  logic [SW-1:0]       srad_q;
  logic [RW+1:0]       srem_q;
  logic [RW-1:0]       root_q;
  logic [CNTW-1:0]     cnt_q;
  logic [1:0]          ax_q;
  logic [PW-1:0]       num_q;
  logic [QW-1:0]       quo_q;
  logic [RW+1:0]       drem_q;
  logic                sneg_q;
  logic                ov_q;
  logic [W-1:0]        ox_q, oy_q, oz_q;
  logic [W-2:0]        or_q;
  logic                osat_q;

  logic signed [DW-1:0] dfull [3];
  logic signed [DW-1:0] drs;
  logic [RW+1:0]        strial, srem_sh;
  logic [RW+1:0]        dvs, drem_sh;
  logic [DW:0]          half_sum;
  logic signed [DW:0]   hsum, axv;
  logic [RW-1:0]        dd;
  logic [RW+1:0]        nr_sum;
  logic signed [W-1:0]  mx;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dfull[a] = $signed({nx_q[a][W-1], nx_q[a]}) - $signed({cx_q[a][W-1], cx_q[a]});
    end
    drs = $signed({2'b00, r2_q}) - $signed({2'b00, r1_q});
  end

  assign srem_sh = {srem_q[RW-1:0], srad_q[SW-1 -: 2]};
  assign strial  = {root_q, 2'b01};
  assign dd      = (root_q == '0) ? RW'(1) : root_q;
  assign dvs     = {1'b0, dd, 1'b0};
  assign drem_sh = {drem_q[RW:0], num_q[PW-1]};

  always_comb begin
    hsum     = $signed({cx_q[ax_q][W-1], cx_q[ax_q][W-1], cx_q[ax_q]})
             + $signed({nx_q[ax_q][W-1], nx_q[ax_q][W-1], nx_q[ax_q]});
    half_sum = {hsum[DW], hsum[DW:1]};
    if (sneg_q) axv = $signed(half_sum) - $signed({1'b0, quo_q[DW-1:0]});
    else        axv = $signed(half_sum) + $signed({1'b0, quo_q[DW-1:0]});
    if (quo_q[QW-1:DW] != '0) axv = sneg_q ? CMinL : CMaxL;
    if (axv > CMaxL)      mx = {1'b0, {(W-1){1'b1}}};
    else if (axv < CMinL) mx = {1'b1, {(W-1){1'b0}}};
    else                  mx = axv[W-1:0];
    nr_sum = RW'(r1_q) + RW'(r2_q) + RW'(dd);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      nx_q[0] <= in_x_i; nx_q[1] <= in_y_i; nx_q[2] <= in_z_i;
      r2_q <= in_r_i; first_q <= in_first_i; last_q <= in_last_i;
    end
    if (cmd_i.mul) begin
      for (int a = 0; a < 3; a++) begin
        da_q[a]   <= dfull[a][DW-1] ? DW'(-dfull[a]) : DW'(dfull[a]);
        dneg_q[a] <= dfull[a][DW-1];
      end
      dr_q    <= drs[DW-1] ? DW'(-drs) : DW'(drs);
      drneg_q <= drs[DW-1];
    end
    if (cmd_i.sum) begin
      for (int a = 0; a < 3; a++) sq_q[a] <= da_q[a] * da_q[a];
      drsq_q <= dr_q * dr_q;
    end
    if (cmd_i.sqrt_start) begin
      srad_q <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
      srem_q <= '0; root_q <= '0; cnt_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      srad_q <= srad_q << 2;
      cnt_q  <= cnt_q + 1'b1;
      if (srem_sh >= strial) begin
        srem_q <= srem_sh - strial; root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        srem_q <= srem_sh;          root_q <= {root_q[RW-2:0], 1'b0};
      end
    end
    if (cmd_i.dprep) begin
      num_q  <= da_q[ax_q] * dr_q;
      sneg_q <= dneg_q[ax_q] ^ drneg_q;
      drem_q <= '0; quo_q <= '0; cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= num_q << 1;
      cnt_q <= cnt_q + 1'b1;
      if (drem_sh >= dvs) begin
        drem_q <= drem_sh - dvs; quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        drem_q <= drem_sh;       quo_q <= {quo_q[QW-2:0], 1'b0};
      end
    end
    if (cmd_i.out_load) begin
      ox_q <= cx_q[0]; oy_q <= cx_q[1]; oz_q <= cx_q[2];
      or_q <= r1_q; osat_q <= sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '{default: '0};
      r1_q <= '0;
    end else begin
      if (cmd_i.axis) begin
        cx_q[ax_q] <= mx;
        if (ax_q == 2'd2) begin
          if (nr_sum[RW:1] > RMaxL) r1_q <= '1;
          else                      r1_q <= nr_sum[W-1:1];
        end
      end
      if (cmd_i.mul && first_q) begin
        cx_q <= nx_q; r1_q <= r2_q;
      end
      if (cmd_i.cmp && cont_q && (r1_q < r2_q)) begin
        cx_q <= nx_q; r1_q <= r2_q;
      end
    end
  end

  assign cont_q = (SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2])) <= SW'(drsq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0; sat_q <= 1'b0; ax_q <= '0;
    end else begin
      if (cmd_i.out_load) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      if (cmd_i.mul && first_q) sat_q <= 1'b0;
      if (cmd_i.axis && ax_q == 2'd2 && nr_sum[RW:1] > RMaxL)
        sat_q <= 1'b1;
      if (cmd_i.sqrt_start) ax_q <= '0;
      else if (cmd_i.axis) ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
    end
  end

  assign sts_o.first     = first_q;
  assign sts_o.last      = last_q;
  assign sts_o.contained = cont_q;
  assign sts_o.sqrt_done = cnt_q == CNTW'(NI - 1);
  assign sts_o.div_done  = cnt_q == CNTW'(PW - 1);
  assign sts_o.axis_last = ax_q == 2'd2;

  assign out_free_o  = !ov_q || out_ready_i;
  assign out_valid_o = ov_q;
  assign out_x_o = ox_q;
  assign out_y_o = oy_q;
  assign out_z_o = oz_q;
  assign out_r_o = or_q;
  assign out_sat_o = osat_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_o)
    else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(out_r_o))
    else $error("held result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.axis |-> ax_q != 2'd3)
    else $error("bad axis");

endmodule
